// File: hw/rtl/fragment_presence_bitmap_macros.svh
// assertion macros for the fragment presence bitmap
// used by the top level; needs no package
`ifndef FRAGMENT_PRESENCE_BITMAP_MACROS_SVH
`define FRAGMENT_PRESENCE_BITMAP_MACROS_SVH

// same-cycle implication under the active-low reset
`define FPB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the active-low reset
`define FPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fpb_pkg.sv
// shared types and constants for the fragment presence bitmap
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fpb_pkg;

  localparam int unsigned MAX_FRAGMENTS_DEF = 4096;
  localparam int unsigned MAX_LIST_DEF      = 64;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned STATUS_W = 2;

  // one map row is one memory word
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFF_W    = 5;
  localparam int unsigned ROWSEL_W = CNT_W - OFF_W;
  localparam int unsigned CNT_LIMIT = (1 << CNT_W) - 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_MARK  = 2'd0,
    FN_CHECK = 2'd1,
    FN_LIST  = 2'd2,
    FN_NONE  = 2'd3
  } fpb_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_RANGE        = 2'd1,
    ST_NONE_MISSING = 2'd2
  } fpb_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_MARK,
    S_CHECK,
    S_SCAN,
    S_REFUSE,
    S_DONE
  } fpb_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  frag_index;
    logic [CAP_W-1:0]  list_capacity;
  } fpb_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                is_present;
    logic [IDX_W-1:0]    missing_index;
    logic                last;
  } fpb_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] pos;
  } fpb_find_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } fpb_stat_t;

endpackage

// File: hw/rtl/fpb_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
// payload type is a parameter; types come from fpb_pkg
`timescale 1ns / 1ps

interface fpb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/fpb_map_ram.sv
// presence map storage: one write port, one read port, registered read data
// depends on fpb_pkg for the word width
`timescale 1ns / 1ps

module fpb_map_ram import fpb_pkg::*; #(
  parameter int unsigned ROWS   = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [ROWS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/fpb_find_zero.sv
// search unit: lowest clear bit of a map row inside a bit window
// depends on fpb_pkg for widths and the result struct
`timescale 1ns / 1ps

module fpb_find_zero import fpb_pkg::*; (
  input  logic [WORD_W-1:0] word_i,
  input  logic [OFF_W-1:0]  start_i,
  input  logic [OFF_W:0]    limit_i,
  output fpb_find_t         find_o
);

  logic [WORD_W-1:0] cand;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      cand[j] = !word_i[j] && (OFF_W'(j) >= start_i) && ((OFF_W + 1)'(j) < limit_i);
    end
  end

  always_comb begin
    find_o.hit = |cand;
    find_o.pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        find_o.pos = OFF_W'(j);
      end
    end
  end

endmodule

// File: hw/rtl/fpb_seq.sv
// sequencer: request decode, map clearing sweep, row fetch and scan, result register
// depends on fpb_pkg; drives fpb_map_ram and fpb_find_zero
`timescale 1ns / 1ps

module fpb_seq import fpb_pkg::*; #(
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
  parameter int unsigned MAX_LIST      = MAX_LIST_DEF,
  parameter int unsigned ROWS          = 128,
  parameter int unsigned ROW_W         = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              req_valid_i,
  input  fpb_req_t          req_data_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  output fpb_rsp_t          rsp_data_o,
  input  logic              rsp_ready_i,
  output logic              ram_we_o,
  output logic [ROW_W-1:0]  ram_waddr_o,
  output logic [WORD_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [ROW_W-1:0]  ram_raddr_o,
  input  logic [WORD_W-1:0] ram_rdata_i,
  output logic [OFF_W-1:0]  find_start_o,
  output logic [OFF_W:0]    find_limit_o,
  input  fpb_find_t         find_i,
  output fpb_stat_t         stat_o
);

  localparam int unsigned EFF_FRAGS = (MAX_FRAGMENTS < CNT_LIMIT) ? MAX_FRAGMENTS : CNT_LIMIT;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(EFF_FRAGS);
  localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(MAX_LIST);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  fpb_state_e          state_q, state_d;
  logic [CNT_W-1:0]    count_q;
  logic [ROW_W-1:0]    clr_q;
  fpb_func_e           func_q;
  logic [CNT_W-1:0]    scan_q;
  logic [CAP_W-1:0]    cap_q;
  logic [CAP_W-1:0]    n_q;
  logic                pend_valid_q;
  logic [IDX_W-1:0]    pend_idx_q;
  logic                out_valid_q;
  fpb_rsp_t            out_data_q;

  logic                in_xfer;
  logic                can_emit;
  logic                emit;
  fpb_rsp_t            emit_rsp;
  logic                take_hit;
  logic [ROWSEL_W-1:0] row_sel;
  logic [ROWSEL_W:0]   row_nxt;
  logic [CNT_W:0]      next_base;
  logic                past_end;
  logic [CNT_W-1:0]    hit_idx;
  logic                cap_hit;
  logic [CNT_W-1:0]    cfg_sat;
  logic [CAP_W-1:0]    cap_sat;

  assign in_xfer   = req_valid_i && req_ready_o;
  assign can_emit  = !out_valid_q || rsp_ready_i;
  assign row_sel   = scan_q[CNT_W-1:OFF_W];
  assign row_nxt   = {1'b0, row_sel} + {{ROWSEL_W{1'b0}}, 1'b1};
  assign next_base = {row_nxt, {OFF_W{1'b0}}};
  assign past_end  = next_base >= {1'b0, count_q};
  assign hit_idx   = {row_sel, find_i.pos};
  // a hit is taken unless an earlier index still waits for the result register
  assign take_hit  = find_i.hit && (!pend_valid_q || can_emit);
  assign cap_hit   = (n_q + CAP_W'(1)) == cap_q;

  assign cfg_sat = (cfg_wdata_i > CNT_MAX) ? CNT_MAX : cfg_wdata_i;

  always_comb begin
    priority if (req_data_i.list_capacity == '0) begin
      cap_sat = CAP_W'(1);
    end else if (req_data_i.list_capacity > CAP_MAX) begin
      cap_sat = CAP_MAX;
    end else begin
      cap_sat = req_data_i.list_capacity;
    end
  end

  // window of the current row that lies at or after the scan point and below the count
  assign find_start_o = scan_q[OFF_W-1:0];
  assign find_limit_o = (row_sel == count_q[CNT_W-1:OFF_W]) ?
                        {1'b0, count_q[OFF_W-1:0]} : (OFF_W + 1)'(WORD_W);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == ROW_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          priority if (req_data_i.func == FN_NONE) begin
            state_d = S_IDLE;
          end else if ({1'b0, req_data_i.frag_index} >= count_q) begin
            state_d = S_REFUSE;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        unique case (func_q)
          FN_MARK:  state_d = S_MARK;
          FN_CHECK: state_d = S_CHECK;
          FN_LIST:  state_d = S_SCAN;
          FN_NONE:  state_d = S_IDLE;
        endcase
      end
      S_MARK, S_CHECK, S_REFUSE, S_DONE: begin
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (take_hit) begin
          priority if (cap_hit) begin
            state_d = S_DONE;
          end else if (find_i.pos == {OFF_W{1'b1}}) begin
            state_d = past_end ? S_DONE : S_FETCH;
          end else begin
            state_d = S_SCAN;
          end
        end else if (!find_i.hit) begin
          state_d = past_end ? S_DONE : S_FETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a count write restarts the clearing sweep
    if (cfg_we_i) begin
      state_d = S_CLEAR;
    end
  end

  // outputs of the sequencer
  always_comb begin
    req_ready_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = scan_q[OFF_W +: ROW_W];
    ram_wdata_o = ram_rdata_i | (WORD_W'(1) << scan_q[OFF_W-1:0]);
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_q[OFF_W +: ROW_W];
    emit        = 1'b0;
    emit_rsp    = '{status: ST_OK, is_present: 1'b0, missing_index: '0, last: 1'b1};
    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
      end
      S_FETCH: begin
        ram_re_o = 1'b1;
      end
      S_MARK: begin
        emit     = can_emit;
        ram_we_o = can_emit;
      end
      S_CHECK: begin
        emit                = can_emit;
        emit_rsp.is_present = ram_rdata_i[scan_q[OFF_W-1:0]];
      end
      S_REFUSE: begin
        emit            = can_emit;
        emit_rsp.status = ST_RANGE;
      end
      S_SCAN: begin
        emit                   = take_hit && pend_valid_q;
        emit_rsp.missing_index = pend_idx_q;
        emit_rsp.last          = 1'b0;
      end
      S_DONE: begin
        emit = can_emit;
        if (pend_valid_q) begin
          emit_rsp.missing_index = pend_idx_q;
        end else begin
          emit_rsp.status = ST_NONE_MISSING;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      count_q      <= '0;
      clr_q        <= '0;
      func_q       <= FN_NONE;
      scan_q       <= '0;
      cap_q        <= CAP_W'(1);
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_sat;
        clr_q   <= '0;
      end else if (state_q == S_CLEAR) begin
        clr_q <= clr_q + ROW_W'(1);
      end
      if (in_xfer) begin
        func_q       <= fpb_func_e'(req_data_i.func);
        scan_q       <= {1'b0, req_data_i.frag_index};
        cap_q        <= cap_sat;
        n_q          <= '0;
        pend_valid_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (take_hit) begin
          pend_valid_q <= 1'b1;
          n_q          <= n_q + CAP_W'(1);
          scan_q       <= hit_idx + CNT_W'(1);
        end else if (!find_i.hit) begin
          scan_q <= next_base[CNT_W-1:0];
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && take_hit) begin
      pend_idx_q <= hit_idx[IDX_W-1:0];
    end
    if (emit) begin
      out_data_q <= emit_rsp;
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign rsp_data_o     = out_data_q;
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign stat_o.busy     = (state_q != S_IDLE);

endmodule

// File: hw/rtl/fragment_presence_bitmap.sv
// fragment presence bitmap: top level tying sequencer, search unit and map memory
// depends on fpb_pkg, fpb_stream_if, fpb_seq, fpb_find_zero, fpb_map_ram and the macro header
//
// Requests arrive on req_i (func, frag_index, list_capacity), results leave on rsp_o
// (status, is_present, missing_index, last); both are valid/ready channels and a
// transfer happens when valid and ready are high at a rising clk_i edge.
// cfg_we_i with cfg_wdata_i writes fragment_count and starts a clearing pass.
// The map is stored as 32-bit rows in a one-read one-write memory; one find-zero unit
// searches the current row. req_i.ready is high only while the sequencer is idle.
// Mark and check: the map row is fetched, then the result enters the output register.
// Refused index: the result enters the output register without a row fetch. List: each
// scanned row is fetched and then searched, each index found is passed on as a result,
// and a final result closes the scan; each result is its own transfer, last flags the
// final one.
// Reset (asynchronous, rst_ni low) and every count write run a clearing pass over
// every map row before the next request is taken.
// A stalled receiver holds the result register; the other states wait for it, a scan stops
// at a new hit while an earlier index waits for it, and nothing is dropped.
`timescale 1ns / 1ps
`include "fragment_presence_bitmap_macros.svh"

module fragment_presence_bitmap import fpb_pkg::*; #(
  parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
  parameter int unsigned MAX_LIST      = MAX_LIST_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  fpb_stream_if.sink       req_i,
  fpb_stream_if.source     rsp_o
);

  localparam int unsigned EFF_FRAGS = (MAX_FRAGMENTS < CNT_LIMIT) ? MAX_FRAGMENTS : CNT_LIMIT;
  localparam int unsigned ROWS      = (EFF_FRAGS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  fpb_req_t          req_data;
  fpb_rsp_t          rsp_data;
  logic              req_ready;
  logic              rsp_valid;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [OFF_W-1:0]  find_start;
  logic [OFF_W:0]    find_limit;
  fpb_find_t         find;
  fpb_stat_t         stat;

  assign req_data    = req_i.data;
  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign rsp_o.data  = rsp_data;

  fpb_seq #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS),
    .MAX_LIST      (MAX_LIST),
    .ROWS          (ROWS),
    .ROW_W         (ROW_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_i.valid),
    .req_data_i   (req_data),
    .req_ready_o  (req_ready),
    .rsp_valid_o  (rsp_valid),
    .rsp_data_o   (rsp_data),
    .rsp_ready_i  (rsp_o.ready),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .find_start_o (find_start),
    .find_limit_o (find_limit),
    .find_i       (find),
    .stat_o       (stat)
  );

  fpb_find_zero u_find (
    .word_i  (ram_rdata),
    .start_i (find_start),
    .limit_i (find_limit),
    .find_o  (find)
  );

  fpb_map_ram #(
    .ROWS   (ROWS),
    .ADDR_W (ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `FPB_ASSERT_NOW(a_clear_blocks_req, clk_i, rst_ni, stat.clearing, !req_ready, "request taken during clearing pass")
  `FPB_ASSERT_NEXT(a_cfg_starts_clear, clk_i, rst_ni, cfg_we_i, stat.clearing, "count write did not start clearing")
  `FPB_ASSERT_NEXT(a_req_makes_busy, clk_i, rst_ni, req_i.valid && req_ready && (req_data.func != FN_NONE), stat.busy, "sequencer idle after accepted request")
  `FPB_ASSERT_NOW(a_present_only_ok, clk_i, rst_ni, rsp_valid && rsp_data.is_present, (rsp_data.status == ST_OK) && rsp_data.last, "presence flag on a non-check result")

endmodule

// File: tb/sv/fragment_presence_bitmap_test.sv
// testbench for fragment_presence_bitmap: directed table, then random phases of requests
// predicts results from its own presence map or a fixed row and checks each transfer
// depends on fpb_pkg, fpb_stream_if and the fragment_presence_bitmap top level
`timescale 1ns / 1ps

module fragment_presence_bitmap_test;
  import fpb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned MAX_GAP       = 19;

  typedef struct {
    bit          is_cfg;
    int unsigned count;
    fpb_req_t    req;
    bit          typed;
    fpb_rsp_t    rsp;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  fpb_stream_if #(.T(fpb_req_t)) req_if ();
  fpb_stream_if #(.T(fpb_rsp_t)) rsp_if ();

  fragment_presence_bitmap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // own copy of the block state
  logic [MAX_FRAGMENTS_DEF-1:0] seen_map = '0;
  int unsigned                  frag_total = 0;

  fpb_rsp_t    awaited_rsp[$];
  fpb_rsp_t    outcome_q[$];
  plan_row_t   plan[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // fills outcome_q with the results one request causes and updates the map
  function automatic void bitmap_outcome(input fpb_req_t r);
    int unsigned cap;
    int unsigned i;
    fpb_rsp_t    o;
    outcome_q.delete();
    if (r.func == FN_NONE) return;
    o = '0;
    o.last = 1'b1;
    if (r.frag_index >= frag_total) begin
      o.status = ST_RANGE;
      outcome_q.push_back(o);
      return;
    end
    o.status = ST_OK;
    case (r.func)
      FN_MARK: begin
        seen_map[r.frag_index] = 1'b1;
        outcome_q.push_back(o);
      end
      FN_CHECK: begin
        o.is_present = seen_map[r.frag_index];
        outcome_q.push_back(o);
      end
      default: begin
        cap = r.list_capacity;
        if (cap == 0) cap = 1;
        if (cap > MAX_LIST_DEF) cap = MAX_LIST_DEF;
        for (i = r.frag_index; i < frag_total && outcome_q.size() < cap; i++) begin
          if (!seen_map[i]) begin
            o = '0;
            o.status = ST_OK;
            o.missing_index = IDX_W'(i);
            outcome_q.push_back(o);
          end
        end
        if (outcome_q.size() == 0) begin
          o = '0;
          o.status = ST_NONE_MISSING;
          o.last = 1'b1;
          outcome_q.push_back(o);
        end else begin
          o = outcome_q.pop_back();
          o.last = 1'b1;
          outcome_q.push_back(o);
        end
      end
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input int unsigned v);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.count = v;
    return row;
  endfunction

  function automatic plan_row_t req_row(input fpb_func_e f, input int unsigned idx,
                                        input int unsigned cap);
    plan_row_t row;
    row = '{default: '0};
    row.req.func = f;
    row.req.frag_index = IDX_W'(idx);
    row.req.list_capacity = CAP_W'(cap);
    return row;
  endfunction

  // single result known at a glance
  function automatic plan_row_t fixed_row(input fpb_func_e f, input int unsigned idx,
                                          input int unsigned cap, input fpb_status_e st,
                                          input logic present);
    plan_row_t row;
    row = req_row(f, idx, cap);
    row.typed = 1'b1;
    row.rsp.status = st;
    row.rsp.is_present = present;
    row.rsp.last = 1'b1;
    return row;
  endfunction

  function automatic void report_fault(input string why, input fpb_rsp_t got,
                                       input fpb_rsp_t want);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch (%s) at cycle %0d: expected status=%0d present=%0d index=%0d last=%0d",
               why, cycle_count, want.status, want.is_present, want.missing_index, want.last);
      $display("  got status=%0d present=%0d index=%0d last=%0d",
               got.status, got.is_present, got.missing_index, got.last);
    end
  endfunction

  task automatic send_request(input fpb_req_t r, input bit typed, input fpb_rsp_t typed_rsp);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk_i); while (!req_if.ready);
    bitmap_outcome(r);
    if (typed) begin
      awaited_rsp.push_back(typed_rsp);
    end else begin
      foreach (outcome_q[k]) awaited_rsp.push_back(outcome_q[k]);
    end
  endtask

  // stop sending and let every awaited result arrive
  task automatic hold_off();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_rsp.size() != 0);
  endtask

  task automatic write_count(input int unsigned v);
    int unsigned w;
    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    w = v & CNT_LIMIT;
    frag_total = (w > MAX_FRAGMENTS_DEF) ? MAX_FRAGMENTS_DEF : w;
    seen_map = '0;
  endtask

  // result side: random stalls, compare every transfer with the oldest expectation
  initial begin
    fpb_rsp_t    got;
    fpb_rsp_t    want;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got = rsp_if.data;
      if (awaited_rsp.size() == 0) begin
        report_fault("unexpected result", got, '0);
      end else begin
        want = awaited_rsp.pop_front();
        if (got.status !== want.status || got.is_present !== want.is_present ||
            got.missing_index !== want.missing_index || got.last !== want.last)
          report_fault("wrong field", got, want);
      end
    end
  end

  initial begin
    fpb_req_t    r;
    fpb_rsp_t    none_rsp;
    int unsigned span;
    int unsigned pick;
    int unsigned n;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    none_rsp = '0;

    // count is zero after reset, so everything is refused
    plan.push_back(fixed_row(FN_CHECK, 0, 1, ST_RANGE, 1'b0));
    plan.push_back(fixed_row(FN_LIST, 0, 64, ST_RANGE, 1'b0));
    // count above maximum saturates
    plan.push_back(cfg_row(8191));
    plan.push_back(fixed_row(FN_MARK, 4095, 0, ST_OK, 1'b0));
    plan.push_back(fixed_row(FN_CHECK, 4095, 127, ST_OK, 1'b1));
    plan.push_back(fixed_row(FN_CHECK, 0, 1, ST_OK, 1'b0));
    plan.push_back(fixed_row(FN_MARK, 0, 64, ST_OK, 1'b0));
    plan.push_back(req_row(FN_LIST, 0, 0));
    plan.push_back(fixed_row(FN_LIST, 4095, 127, ST_NONE_MISSING, 1'b0));
    plan.push_back(req_row(FN_LIST, 0, 127));
    plan.push_back(req_row(FN_NONE, 4095, 127));
    plan.push_back(req_row(FN_LIST, 4000, 64));
    plan.push_back(fixed_row(FN_MARK, 2048, 127, ST_OK, 1'b0));
    plan.push_back(fixed_row(FN_CHECK, 2048, 3, ST_OK, 1'b1));
    plan.push_back(cfg_row(0));
    plan.push_back(fixed_row(FN_MARK, 0, 1, ST_RANGE, 1'b0));
    plan.push_back(fixed_row(FN_CHECK, 4095, 1, ST_RANGE, 1'b0));
    plan.push_back(cfg_row(1));
    plan.push_back(fixed_row(FN_MARK, 0, 1, ST_OK, 1'b0));
    plan.push_back(fixed_row(FN_LIST, 0, 1, ST_NONE_MISSING, 1'b0));
    plan.push_back(fixed_row(FN_CHECK, 0, 1, ST_OK, 1'b1));
    plan.push_back(cfg_row(8));
    plan.push_back(req_row(FN_LIST, 0, 64));
    plan.push_back(fixed_row(FN_MARK, 7, 1, ST_OK, 1'b0));
    plan.push_back(req_row(FN_LIST, 3, 2));
    plan.push_back(fixed_row(FN_CHECK, 8, 1, ST_RANGE, 1'b0));
    // a count write clears the map
    plan.push_back(cfg_row(4096));
    plan.push_back(fixed_row(FN_CHECK, 4095, 1, ST_OK, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_count(plan[k].count);
      else send_request(plan[k].req, plan[k].typed, plan[k].rsp);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_count(MAX_FRAGMENTS_DEF);
        1: write_count($urandom_range(4097, 8191));
        2: write_count($urandom_range(2, 12));
        3: write_count(1);
        4: write_count($urandom_range(1, 4096));
        5: write_count(0);
        6: write_count($urandom_range(65, 600));
        default: write_count(8191);
      endcase
      quiet = (ph % 3 == 2);
      n = 0;
      while (n < 23) begin
        pick = $urandom_range(0, 99);
        span = (frag_total == 0) ? MAX_FRAGMENTS_DEF : frag_total;
        // mostly indexes inside the tracked range so marks and lists do real work
        r.frag_index = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, span - 1))
                                                    : IDX_W'($urandom());
        r.list_capacity = ($urandom_range(0, 3) == 0) ? CAP_W'($urandom())
                                                      : CAP_W'($urandom_range(1, 16));
        if (pick < 4) r.func = FN_NONE;
        else if (pick < 45) r.func = FN_MARK;
        else if (pick < 70) r.func = FN_CHECK;
        else r.func = FN_LIST;
        send_request(r, 1'b0, none_rsp);
        if (r.func != FN_NONE) begin
          n++;
          if (ph == 4 && n == 13) hold_off();
        end
      end
    end

    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && awaited_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fpb_pkg.sv
hw/rtl/fpb_stream_if.sv
hw/rtl/fpb_map_ram.sv
hw/rtl/fpb_find_zero.sv
hw/rtl/fpb_seq.sv
hw/rtl/fragment_presence_bitmap.sv
tb/sv/fragment_presence_bitmap_test.sv
